>>> rtl/eis_pkg.sv
// Shared constants, types and helpers of the extended integer sorter.
`default_nettype none
package eis_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [1:0] KIND_FINITE     = 2'd0;
    localparam logic [1:0] KIND_MINUS      = 2'd1;
    localparam logic [1:0] KIND_PLUS       = 2'd2;
    // Kind code three is accepted on input and treated as plus infinity.
    localparam logic [1:0] KIND_ALIAS_PLUS = 2'd3;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    // Rank so that minus infinity < finite < plus infinity.
    function automatic logic [1:0] kind_rank(input logic [1:0] kind);
        logic [1:0] rank;
        unique case (kind)
            KIND_MINUS:  rank = 2'd0;
            KIND_FINITE: rank = 2'd1;
            default:     rank = 2'd2;
        endcase
        return rank;
    endfunction

endpackage
`default_nettype wire

>>> rtl/eis_in_if.sv
// Input channel of the sorter: one element per transaction.
`default_nettype none
interface eis_in_if #(
    parameter int VALUE_BITS = eis_pkg::VALUE_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic [1:0]                   kind;
    logic                         last;

    modport source (output valid, value, kind, last, input ready);
    modport sink   (input valid, value, kind, last, output ready);
endinterface
`default_nettype wire

>>> rtl/eis_out_if.sv
// Output channel of the sorter: one sorted element per transaction.
`default_nettype none
interface eis_out_if #(
    parameter int VALUE_BITS = eis_pkg::VALUE_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] sorted_value;
    logic [1:0]                   sorted_kind;
    logic                         end_of_set;
    logic                         overflow;

    modport source (output valid, sorted_value, sorted_kind, end_of_set, overflow,
                    input ready);
    modport sink   (input valid, sorted_value, sorted_kind, end_of_set, overflow,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/eis_cell.sv
// One cell of the insertion chain: holds a single element in sorted position.
`default_nettype none
module eis_cell #(
    parameter int VALUE_BITS = eis_pkg::VALUE_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  eis_pkg::cell_ctrl_t          ctrl,
    input  wire  [1:0]                   new_kind,
    input  wire  signed [VALUE_BITS-1:0] new_value,
    input  wire                          prev_lt,
    input  wire                          prev_valid,
    input  wire  [1:0]                   prev_kind,
    input  wire  signed [VALUE_BITS-1:0] prev_value,
    input  wire                          next_valid,
    input  wire  [1:0]                   next_kind,
    input  wire  signed [VALUE_BITS-1:0] next_value,
    output logic                         lt,
    output logic                         valid,
    output logic [1:0]                   kind,
    output logic signed [VALUE_BITS-1:0] value
);
    import eis_pkg::*;

    localparam int KEY_BITS = VALUE_BITS + 2;

    logic                         valid_reg, valid_next;
    logic [1:0]                   kind_reg, kind_next;
    logic signed [VALUE_BITS-1:0] value_reg, value_next;
    logic [KEY_BITS-1:0]          new_key, own_key;

    // Flipping the sign bit turns signed order into unsigned order.
    assign new_key = {kind_rank(new_kind), new_value[VALUE_BITS-1] ^ 1'b1,
                      new_value[VALUE_BITS-2:0]};
    assign own_key = {kind_rank(kind_reg), value_reg[VALUE_BITS-1] ^ 1'b1,
                      value_reg[VALUE_BITS-2:0]};

    // An empty cell counts as larger than any element.
    assign lt = !valid_reg || (new_key < own_key);

    always_comb
    begin
        priority if (ctrl.shift)
        begin
            valid_next = next_valid;
            kind_next  = next_kind;
            value_next = next_value;
        end
        else if (ctrl.insert && prev_lt)
        begin
            // The new element lands further up, so this cell takes its neighbor.
            valid_next = prev_valid;
            kind_next  = prev_kind;
            value_next = prev_value;
        end
        else if (ctrl.insert && lt)
        begin
            valid_next = 1'b1;
            kind_next  = new_kind;
            value_next = new_value;
        end
        else
        begin
            valid_next = valid_reg;
            kind_next  = kind_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign kind  = kind_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

>>> rtl/extended_integer_sorter.sv
// Top level of the extended integer sorter: insertion chain and run control.
//
// Elements enter one per cycle and are placed in order as they arrive by a
// chain of CAPACITY cells, each comparing the incoming element against its
// own. Once the element marked last is taken, the input stalls and the set
// streams out of the head of the chain in ascending order (minus infinity,
// finite values, plus infinity), one transaction per cycle while the sink is
// ready; the whole chain shifts one place per transaction. Elements
// beyond CAPACITY are dropped and every result of that set has overflow set.
`default_nettype none
module extended_integer_sorter #(
    parameter int CAPACITY   = eis_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = eis_pkg::VALUE_BITS_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    eis_in_if.sink    items,
    eis_out_if.source results
);
    import eis_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             draining_reg, draining_next;
    logic             ovf_reg, ovf_next;

    logic                         in_fire, out_fire, full;
    logic [1:0]                   norm_kind;
    logic signed [VALUE_BITS-1:0] norm_value;
    cell_ctrl_t                   ctrl;

    logic                         c_lt    [CAPACITY];
    logic                         c_valid [CAPACITY];
    logic [1:0]                   c_kind  [CAPACITY];
    logic signed [VALUE_BITS-1:0] c_value [CAPACITY];

    assign items.ready = !draining_reg;
    assign in_fire     = items.valid && items.ready;
    assign out_fire    = results.valid && results.ready;
    assign full        = (count_reg == CNT_W'(CAPACITY));

    // Kind three folds into plus infinity; infinities carry a zero value.
    always_comb
    begin
        norm_kind  = (items.kind == KIND_ALIAS_PLUS) ? KIND_PLUS : items.kind;
        norm_value = (norm_kind == KIND_FINITE) ? items.value : '0;
    end

    assign ctrl.insert = in_fire && !full;
    assign ctrl.shift  = out_fire;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                         p_lt, p_valid, n_valid;
        logic [1:0]                   p_kind, n_kind;
        logic signed [VALUE_BITS-1:0] p_value, n_value;

        if (i == 0)
        begin : g_head
            assign p_lt    = 1'b0;
            assign p_valid = 1'b0;
            assign p_kind  = KIND_FINITE;
            assign p_value = '0;
        end
        else
        begin : g_body
            assign p_lt    = c_lt[i-1];
            assign p_valid = c_valid[i-1];
            assign p_kind  = c_kind[i-1];
            assign p_value = c_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_kind  = KIND_FINITE;
            assign n_value = '0;
        end
        else
        begin : g_inner
            assign n_valid = c_valid[i+1];
            assign n_kind  = c_kind[i+1];
            assign n_value = c_value[i+1];
        end

        eis_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_kind  (norm_kind),
            .new_value (norm_value),
            .prev_lt   (p_lt),
            .prev_valid(p_valid),
            .prev_kind (p_kind),
            .prev_value(p_value),
            .next_valid(n_valid),
            .next_kind (n_kind),
            .next_value(n_value),
            .lt        (c_lt[i]),
            .valid     (c_valid[i]),
            .kind      (c_kind[i]),
            .value     (c_value[i])
        );
    end

    always_comb
    begin
        count_next    = count_reg;
        draining_next = draining_reg;
        ovf_next      = ovf_reg;
        if (in_fire)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (items.last)
            begin
                draining_next = 1'b1;
            end
        end
        if (out_fire)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                draining_next = 1'b0;
                ovf_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            draining_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            draining_reg <= draining_next;
            ovf_reg      <= ovf_next;
        end
    end

    assign results.valid        = draining_reg;
    assign results.sorted_value = c_value[0];
    assign results.sorted_kind  = c_kind[0];
    assign results.end_of_set   = (count_reg == CNT_W'(1));
    assign results.overflow     = ovf_reg;

endmodule
`default_nettype wire
